FILE: hdl/msf_pkg.sv
package msf_pkg;

  localparam int unsigned NumPartsDefault = 14;
  localparam int unsigned ShadowDepth     = 512;
  localparam int unsigned ShadowAw        = 9;
  localparam int unsigned UcodeAw         = 5;

  localparam logic [8:0] AddrModeCtl     = 9'h029;
  localparam logic [8:0] AddrPanBank0    = 9'h0b4;
  localparam logic [8:0] AddrPanBank1    = 9'h1b4;
  localparam logic [8:0] AddrSsgLevel    = 9'h008;
  localparam logic [8:0] AddrRhythmLevel = 9'h011;
  localparam logic [8:0] AddrAdpcmLevel  = 9'h10b;

  localparam logic [7:0] ModeForceBit    = 8'h80;
  localparam logic [7:0] PanClearMask    = 8'h3f;
  localparam logic [7:0] SsgClearMask    = 8'hf0;
  localparam logic [7:0] PanReplayOn     = 8'hf7;
  localparam logic [7:0] PanReplayOff    = 8'h37;
  localparam logic [7:0] SsgReplayOn     = 8'h1f;
  localparam logic [7:0] SsgReplayOff    = 8'h10;
  localparam logic [7:0] RhythmMask      = 8'h3f;

  localparam logic [3:0] PartAdpcm  = 4'd12;
  localparam logic [3:0] PartRhythm = 4'd13;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_MUTE  = 2'd2,
    CMD_SOLO  = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_WRITE,
    ACT_RD_ITEM,
    ACT_EMIT_READ,
    ACT_SET_MUTE,
    ACT_SET_SOLO,
    ACT_RD_REPLAY,
    ACT_EMIT_REPLAY
  } act_e;

  localparam logic [UcodeAw-1:0] PcWrite = 5'd0;
  localparam logic [UcodeAw-1:0] PcRead  = 5'd1;
  localparam logic [UcodeAw-1:0] PcMute  = 5'd3;
  localparam logic [UcodeAw-1:0] PcSolo  = 5'd6;

  typedef struct packed {
    cmd_e       command;
    logic [8:0] reg_address;
    logic [7:0] write_value;
    logic [3:0] part_number;
    logic       flag_on;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [8:0] out_address;
    logic [7:0] out_value;
    logic       is_last;
  } out_item_t;

  typedef struct packed {
    act_e       act;
    logic       part_sel_item;
    logic [3:0] part;
    logic       last;
    logic       done;
    logic       jmp_noreg;
  } ctrl_t;

  typedef struct packed {
    logic       start;
    cmd_e       command;
    logic       stall;
    logic       noreg;
  } seq_in_t;

  function automatic logic part_has_reg(logic [3:0] p);
    return (p <= 4'd2) || ((p >= 4'd6) && (p <= 4'd13));
  endfunction

  function automatic logic [8:0] replay_addr(logic [3:0] p);
    logic [8:0] a;
    a = '0;
    if (p <= 4'd2) begin
      a = AddrPanBank0 + {5'd0, p};
    end else if ((p >= 4'd6) && (p <= 4'd8)) begin
      a = AddrPanBank1 + {5'd0, p - 4'd6};
    end else if ((p >= 4'd9) && (p <= 4'd11)) begin
      a = AddrSsgLevel + {5'd0, p - 4'd9};
    end else if (p == PartAdpcm) begin
      a = AddrAdpcmLevel;
    end else if (p == PartRhythm) begin
      a = AddrRhythmLevel;
    end
    return a;
  endfunction

  function automatic logic [7:0] replay_value(logic [3:0] p, logic m, logic [7:0] d);
    logic [7:0] v;
    v = '0;
    if ((p <= 4'd2) || ((p >= 4'd6) && (p <= 4'd8))) begin
      v = d & (m ? PanReplayOff : PanReplayOn);
    end else if ((p >= 4'd9) && (p <= 4'd11)) begin
      v = d & (m ? SsgReplayOff : SsgReplayOn);
    end else if (p == PartAdpcm) begin
      v = m ? 8'h00 : d;
    end else if (p == PartRhythm) begin
      v = m ? 8'h00 : (d & RhythmMask);
    end
    return v;
  endfunction

endpackage

FILE: hdl/sound_chip_mute_solo_filter.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  in_item_i  (in_item_t)
// out      output     out_valid_o / out_ready_i out_item_o (out_item_t)
//
// After reset the shadow memory is cleared one entry a cycle, all 512, with in_ready_o low.
// A write is an emit step, a read a shadow read step and an emit step.
// Mute and solo set a flag, then replay registered parts, each a shadow read and an emit step.
// An emit step waits while the output register holds an item not yet taken.
module sound_chip_mute_solo_filter
  import msf_pkg::*;
#(
  parameter int unsigned NumParts = NumPartsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  in_item_t            item_q;
  out_item_t           out_q;
  logic                out_valid_q;
  logic [NumParts-1:0] mute_q, solo_q, muted_vec;
  logic                clr_busy_q;
  logic [ShadowAw-1:0] clr_cnt_q;

  ctrl_t               ctrl;
  seq_in_t             seq_in;
  logic                busy, accept, emit, stall, emit_go;
  logic [3:0]          cur_part;
  logic                cur_muted;
  logic                ram_we, ram_re;
  logic [ShadowAw-1:0] ram_addr;
  logic [7:0]          ram_wdata, ram_rdata;
  logic [3:0]          wr_part;
  logic                wr_hit;
  logic [7:0]          wr_value;

  assign in_ready_o  = !clr_busy_q && !busy;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign emit    = busy && ((ctrl.act == ACT_WRITE) || (ctrl.act == ACT_EMIT_READ) ||
                            (ctrl.act == ACT_EMIT_REPLAY));
  assign stall   = emit && out_valid_q && !out_ready_i;
  assign emit_go = emit && !stall;

  assign seq_in = '{start: accept, command: in_item_i.command, stall: stall,
                    noreg: !part_has_reg(item_q.part_number)};

  msf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seq_i  (seq_in),
    .busy_o (busy),
    .ctrl_o (ctrl)
  );

  assign muted_vec = mute_q | ({NumParts{|solo_q}} & ~solo_q);
  assign cur_part  = ctrl.part_sel_item ? item_q.part_number : ctrl.part;
  assign cur_muted = (int'(cur_part) < NumParts) ? muted_vec[cur_part] : 1'b0;

  always_comb begin
    wr_part  = '0;
    wr_hit   = 1'b0;
    wr_value = item_q.write_value;
    priority if (item_q.reg_address == AddrModeCtl) begin
      wr_value = item_q.write_value | ModeForceBit;
    end else if ((item_q.reg_address >= AddrPanBank0) &&
                 (item_q.reg_address <= AddrPanBank0 + 9'd2)) begin
      wr_hit  = 1'b1;
      wr_part = 4'(item_q.reg_address - AddrPanBank0);
    end else if ((item_q.reg_address >= AddrPanBank1) &&
                 (item_q.reg_address <= AddrPanBank1 + 9'd2)) begin
      wr_hit  = 1'b1;
      wr_part = 4'd6 + 4'(item_q.reg_address - AddrPanBank1);
    end else if ((item_q.reg_address >= AddrSsgLevel) &&
                 (item_q.reg_address <= AddrSsgLevel + 9'd2)) begin
      wr_hit  = 1'b1;
      wr_part = 4'd9 + 4'(item_q.reg_address - AddrSsgLevel);
    end else if (item_q.reg_address == AddrRhythmLevel) begin
      wr_hit  = 1'b1;
      wr_part = PartRhythm;
    end else if (item_q.reg_address == AddrAdpcmLevel) begin
      wr_hit  = 1'b1;
      wr_part = PartAdpcm;
    end else begin
      wr_value = item_q.write_value;
    end
    if (wr_hit && (int'(wr_part) < NumParts) && muted_vec[wr_part]) begin
      if (wr_part <= 4'd8) begin
        wr_value = item_q.write_value & PanClearMask;
      end else if (wr_part <= 4'd11) begin
        wr_value = item_q.write_value & SsgClearMask;
      end else begin
        wr_value = 8'h00;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = item_q.reg_address;
    ram_wdata = item_q.write_value;
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = 8'h00;
    end else if (busy) begin
      ram_we = (ctrl.act == ACT_WRITE) && !stall;
      ram_re = (ctrl.act == ACT_RD_ITEM) || (ctrl.act == ACT_RD_REPLAY);
      if (ctrl.act == ACT_RD_REPLAY) begin
        ram_addr = replay_addr(cur_part);
      end
    end
  end

  msf_ram #(
    .Width (8),
    .Depth (ShadowDepth)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (emit_go) begin
      out_q.is_last <= ctrl.last;
      unique case (ctrl.act)
        ACT_EMIT_READ: begin
          out_q.kind        <= KIND_READ;
          out_q.out_address <= item_q.reg_address;
          out_q.out_value   <= ram_rdata;
        end
        ACT_EMIT_REPLAY: begin
          out_q.kind        <= KIND_WRITE;
          out_q.out_address <= replay_addr(cur_part);
          out_q.out_value   <= replay_value(cur_part, cur_muted, ram_rdata);
        end
        default: begin
          out_q.kind        <= KIND_WRITE;
          out_q.out_address <= item_q.reg_address;
          out_q.out_value   <= wr_value;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mute_q      <= '0;
      solo_q      <= '0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == ShadowAw'(ShadowDepth - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (busy && (int'(item_q.part_number) < NumParts)) begin
        if (ctrl.act == ACT_SET_MUTE) begin
          mute_q[item_q.part_number] <= item_q.flag_on;
        end
        if (ctrl.act == ACT_SET_SOLO) begin
          solo_q[item_q.part_number] <= item_q.flag_on;
        end
      end
    end
  end

endmodule

FILE: hdl/msf_ram.sv
module msf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/msf_seq.sv
module msf_seq
  import msf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  seq_in_t seq_i,
  output logic    busy_o,
  output ctrl_t   ctrl_o
);

  logic [UcodeAw-1:0] pc_q, pc_d;
  logic               busy_q, busy_d;

  function automatic ctrl_t ucode(logic [UcodeAw-1:0] pc);
    ctrl_t c;
    c = '{act: ACT_NOP, part_sel_item: 1'b0, part: 4'd0, last: 1'b0, done: 1'b1,
          jmp_noreg: 1'b0};
    unique case (pc)
      5'd0:  c = '{ACT_WRITE,       1'b0, 4'd0,  1'b1, 1'b1, 1'b0};
      5'd1:  c = '{ACT_RD_ITEM,     1'b0, 4'd0,  1'b0, 1'b0, 1'b0};
      5'd2:  c = '{ACT_EMIT_READ,   1'b0, 4'd0,  1'b1, 1'b1, 1'b0};
      5'd3:  c = '{ACT_SET_MUTE,    1'b1, 4'd0,  1'b0, 1'b0, 1'b1};
      5'd4:  c = '{ACT_RD_REPLAY,   1'b1, 4'd0,  1'b0, 1'b0, 1'b0};
      5'd5:  c = '{ACT_EMIT_REPLAY, 1'b1, 4'd0,  1'b1, 1'b1, 1'b0};
      5'd6:  c = '{ACT_SET_SOLO,    1'b0, 4'd0,  1'b0, 1'b0, 1'b0};
      5'd7:  c = '{ACT_RD_REPLAY,   1'b0, 4'd0,  1'b0, 1'b0, 1'b0};
      5'd8:  c = '{ACT_EMIT_REPLAY, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0};
      5'd9:  c = '{ACT_RD_REPLAY,   1'b0, 4'd1,  1'b0, 1'b0, 1'b0};
      5'd10: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd1,  1'b0, 1'b0, 1'b0};
      5'd11: c = '{ACT_RD_REPLAY,   1'b0, 4'd2,  1'b0, 1'b0, 1'b0};
      5'd12: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd2,  1'b0, 1'b0, 1'b0};
      5'd13: c = '{ACT_RD_REPLAY,   1'b0, 4'd6,  1'b0, 1'b0, 1'b0};
      5'd14: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd6,  1'b0, 1'b0, 1'b0};
      5'd15: c = '{ACT_RD_REPLAY,   1'b0, 4'd7,  1'b0, 1'b0, 1'b0};
      5'd16: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd7,  1'b0, 1'b0, 1'b0};
      5'd17: c = '{ACT_RD_REPLAY,   1'b0, 4'd8,  1'b0, 1'b0, 1'b0};
      5'd18: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd8,  1'b0, 1'b0, 1'b0};
      5'd19: c = '{ACT_RD_REPLAY,   1'b0, 4'd9,  1'b0, 1'b0, 1'b0};
      5'd20: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd9,  1'b0, 1'b0, 1'b0};
      5'd21: c = '{ACT_RD_REPLAY,   1'b0, 4'd10, 1'b0, 1'b0, 1'b0};
      5'd22: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd10, 1'b0, 1'b0, 1'b0};
      5'd23: c = '{ACT_RD_REPLAY,   1'b0, 4'd11, 1'b0, 1'b0, 1'b0};
      5'd24: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd11, 1'b0, 1'b0, 1'b0};
      5'd25: c = '{ACT_RD_REPLAY,   1'b0, 4'd12, 1'b0, 1'b0, 1'b0};
      5'd26: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd12, 1'b0, 1'b0, 1'b0};
      5'd27: c = '{ACT_RD_REPLAY,   1'b0, 4'd13, 1'b0, 1'b0, 1'b0};
      5'd28: c = '{ACT_EMIT_REPLAY, 1'b0, 4'd13, 1'b1, 1'b1, 1'b0};
      default: c = '{ACT_NOP,       1'b0, 4'd0,  1'b0, 1'b1, 1'b0};
    endcase
    return c;
  endfunction

  assign ctrl_o = ucode(pc_q);
  assign busy_o = busy_q;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (seq_i.start) begin
      busy_d = 1'b1;
      unique case (seq_i.command)
        CMD_WRITE: pc_d = PcWrite;
        CMD_READ:  pc_d = PcRead;
        CMD_MUTE:  pc_d = PcMute;
        CMD_SOLO:  pc_d = PcSolo;
      endcase
    end else if (busy_q && !seq_i.stall) begin
      if (ctrl_o.done || (ctrl_o.jmp_noreg && seq_i.noreg)) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule
